[hw/rtl/wcs_pkg.sv]
// Shared codes, types and widths of the weighted cell sampler.
package wcs_pkg;

   typedef logic [1:0] func_type;
   typedef logic [1:0] status_type;

   localparam func_type FUNC_CLEAR  = 2'd0;
   localparam func_type FUNC_APPEND = 2'd1;
   localparam func_type FUNC_DRAW   = 2'd2;

   localparam status_type STATUS_OK   = 2'd0;
   localparam status_type STATUS_FULL = 2'd1;
   localparam status_type STATUS_ZERO = 2'd2;

   // operand width of the shared multiplier
   localparam int MUL_BITS = 32;
   // width of the cell_index result field
   localparam int RSP_INDEX_BITS = 10;

endpackage

[hw/rtl/weighted_cell_sampler.sv]
// Weighted cell sampler: inverse-CDF draw over appended weights by binary search.
//
// A transaction is taken on a rising edge with start high and busy low. Clear,
// append and a draw against a zero total finish at once: the result is strobed on
// rsp_valid in the next cycle and busy never rises, so one such transaction can be
// taken every cycle. A draw with a nonzero total raises busy: the threshold
// floor(fraction * total / 2^FRACTION_BITS) is formed in ST_MUL_LO, ST_MUL_HI
// and ST_SUM by two passes through one shared 32x32 multiplier plus a final add,
// then the index is resolved by a row of log2(MAX_CELLS) registered search
// cells, each settling one index bit. The draw's result is strobed once the last
// cell has its index, and the next transaction can be taken on the edge that
// ends that strobe cycle. The receiver cannot stall: rsp_valid is high for one
// cycle only and the result must be captured then. The prefix table lives in the
// cells, no reset pass is needed; entries at or above the cell count are never used.
module weighted_cell_sampler
   import wcs_pkg::*;
#(
   parameter int MAX_CELLS     = 1024,
   parameter int WEIGHT_BITS   = 32,
   parameter int FRACTION_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_func,
   input  logic [31:0]               req_weight,
   input  logic [31:0]               req_random_fraction,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [RSP_INDEX_BITS-1:0] rsp_cell_index
);

   localparam int IDX_BITS   = $clog2(MAX_CELLS);
   localparam int CNT_BITS   = $clog2(MAX_CELLS + 1);
   localparam int TOTAL_BITS = WEIGHT_BITS + IDX_BITS;
   localparam int WIN_BITS   = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
   localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_CELLS);

   // sequencer
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL_LO = 3'd1;
   localparam logic [2:0] ST_MUL_HI = 3'd2;
   localparam logic [2:0] ST_SUM    = 3'd3;
   localparam logic [2:0] ST_SEARCH = 3'd4;

   logic [2:0]                state_ff,  state_in;
   logic [CNT_BITS-1:0]       count_ff,  count_in;
   logic [TOTAL_BITS-1:0]     total_ff,  total_in;
   logic [MUL_BITS-1:0]       frac_ff,   frac_in;
   logic [2*MUL_BITS-1:0]     p_lo_ff,   p_lo_in;
   logic                      rsp_valid_ff,  rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [RSP_INDEX_BITS-1:0] rsp_index_ff,  rsp_index_in;

   logic                      accept;
   func_type                  func;
   logic [TOTAL_BITS-1:0]     weight_ext;
   logic [2*MUL_BITS-1:0]     total_wide;
   logic [MUL_BITS-1:0]       mul_b;
   logic [2*MUL_BITS-1:0]     product;
   logic [3*MUL_BITS-1:0]     prod_sum;
   logic [TOTAL_BITS-1:0]     threshold;

   logic                      wr_en;
   logic                      launch;
   logic                      done;
   logic [IDX_BITS-1:0]       done_idx;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign func       = req_func;
   assign weight_ext = TOTAL_BITS'(req_weight[WIN_BITS-1:0]);
   assign total_wide = (2*MUL_BITS)'(total_ff);

   // low half of the total first, high half next
   assign mul_b = (state_ff == ST_MUL_LO) ? total_wide[MUL_BITS-1:0]
                                          : total_wide[2*MUL_BITS-1:MUL_BITS];

   wcs_mul u_mul (
      .clock   (clock),
      .op_a    (frac_ff),
      .op_b    (mul_b),
      .product (product)
   );

   // product holds the high partial product in ST_SUM
   assign prod_sum  = {product, {MUL_BITS{1'b0}}} + (3*MUL_BITS)'(p_lo_ff);
   assign threshold = TOTAL_BITS'(prod_sum >> FRACTION_BITS);

   // table write on an append that fits
   assign wr_en  = accept && (func == FUNC_APPEND) && (count_ff < MAX_COUNT);
   assign launch = (state_ff == ST_SUM);

   wcs_chain #(
      .IDX_BITS   (IDX_BITS),
      .CNT_BITS   (CNT_BITS),
      .TOTAL_BITS (TOTAL_BITS)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .count    (count_ff),
      .wr_en    (wr_en),
      .wr_addr  (IDX_BITS'(count_ff)),
      .wr_data  (total_ff),
      .launch   (launch),
      .launch_x (threshold),
      .done     (done),
      .done_idx (done_idx)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      frac_in       = frac_ff;
      p_lo_in       = p_lo_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_status_in = STATUS_OK;
               rsp_index_in  = '0;
               unique case (func)
                  FUNC_CLEAR: begin
                     count_in     = '0;
                     total_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_APPEND: begin
                     if (count_ff < MAX_COUNT) begin
                        count_in = count_ff + CNT_BITS'(1);
                        total_in = total_ff + weight_ext;
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_DRAW: begin
                     if (total_ff == '0) begin
                        rsp_status_in = STATUS_ZERO;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        frac_in  = MUL_BITS'(req_random_fraction[FRACTION_BITS-1:0]);
                        state_in = ST_MUL_LO;
                     end
                  end
                  default: begin
                     // unused code: no state change, plain OK
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            p_lo_in  = product;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_index_in  = RSP_INDEX_BITS'(done_idx);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff       <= frac_in;
      p_lo_ff       <= p_lo_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cell_index = rsp_index_ff;

endmodule

[hw/rtl/wcs_mul.sv]
// Registered MUL_BITS x MUL_BITS unsigned multiplier.
module wcs_mul
   import wcs_pkg::*;
(
   input  logic                    clock,
   input  logic [MUL_BITS-1:0]     op_a,
   input  logic [MUL_BITS-1:0]     op_b,
   output logic [2*MUL_BITS-1:0]   product
);

   logic [2*MUL_BITS-1:0] product_ff;
   logic [2*MUL_BITS-1:0] product_in;

   assign product_in = (2*MUL_BITS)'(op_a) * (2*MUL_BITS)'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

[hw/rtl/wcs_cell.sv]
// One search level: holds the prefix starts whose index has its lowest set bit at LEVEL.
module wcs_cell #(
   parameter int LEVEL      = 0,
   parameter int IDX_BITS   = 10,
   parameter int CNT_BITS   = 11,
   parameter int TOTAL_BITS = 42
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CNT_BITS-1:0]   count,
   input  logic                  wr_en,
   input  logic [IDX_BITS-1:0]   wr_addr,
   input  logic [TOTAL_BITS-1:0] wr_data,
   input  logic                  in_valid,
   input  logic [IDX_BITS-1:0]   in_idx,
   input  logic [TOTAL_BITS-1:0] in_x,
   output logic                  out_valid,
   output logic [IDX_BITS-1:0]   out_idx,
   output logic [TOTAL_BITS-1:0] out_x
);

   localparam int ABITS = (IDX_BITS - 1 - LEVEL > 0) ? (IDX_BITS - 1 - LEVEL) : 1;
   localparam int DEPTH = 1 << ABITS;
   localparam logic [IDX_BITS-1:0] BIT_MASK = IDX_BITS'(1) << LEVEL;
   localparam logic [IDX_BITS-1:0] LOW_MASK = BIT_MASK - IDX_BITS'(1);

   logic [TOTAL_BITS-1:0] mem [DEPTH];

   logic                  valid_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [TOTAL_BITS-1:0] x_ff;
   logic [TOTAL_BITS-1:0] rd_ff;

   logic                  wr_hit;
   logic [ABITS-1:0]      wr_row;
   logic [ABITS-1:0]      rd_row;
   logic [IDX_BITS-1:0]   cand;
   logic                  take;

   // entry belongs here when its lowest set bit is LEVEL
   assign wr_hit = wr_en && ((wr_addr & BIT_MASK) != '0) && ((wr_addr & LOW_MASK) == '0);
   assign wr_row = ABITS'(wr_addr >> (LEVEL + 1));
   assign rd_row = ABITS'(in_idx >> (LEVEL + 1));

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[wr_row] <= wr_data;
      end
      rd_ff <= mem[rd_row];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= in_idx;
      x_ff   <= in_x;
   end

   // move up to the candidate if it exists and starts at or below the threshold
   assign cand = idx_ff | BIT_MASK;
   assign take = (CNT_BITS'(cand) < count) && (rd_ff <= x_ff);

   assign out_valid = valid_ff;
   assign out_idx   = take ? cand : idx_ff;
   assign out_x     = x_ff;

endmodule

[hw/rtl/wcs_chain.sv]
// Row of search cells, one per index bit, most significant level first.
module wcs_chain #(
   parameter int IDX_BITS   = 10,
   parameter int CNT_BITS   = 11,
   parameter int TOTAL_BITS = 42
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CNT_BITS-1:0]   count,
   input  logic                  wr_en,
   input  logic [IDX_BITS-1:0]   wr_addr,
   input  logic [TOTAL_BITS-1:0] wr_data,
   input  logic                  launch,
   input  logic [TOTAL_BITS-1:0] launch_x,
   output logic                  done,
   output logic [IDX_BITS-1:0]   done_idx
);

   logic                  link_valid [IDX_BITS+1];
   logic [IDX_BITS-1:0]   link_idx   [IDX_BITS+1];
   logic [TOTAL_BITS-1:0] link_x     [IDX_BITS+1];

   assign link_valid[IDX_BITS] = launch;
   assign link_idx[IDX_BITS]   = '0;
   assign link_x[IDX_BITS]     = launch_x;

   for (genvar lvl = 0; lvl < IDX_BITS; lvl++) begin : g_cell
      wcs_cell #(
         .LEVEL      (lvl),
         .IDX_BITS   (IDX_BITS),
         .CNT_BITS   (CNT_BITS),
         .TOTAL_BITS (TOTAL_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count     (count),
         .wr_en     (wr_en),
         .wr_addr   (wr_addr),
         .wr_data   (wr_data),
         .in_valid  (link_valid[lvl+1]),
         .in_idx    (link_idx[lvl+1]),
         .in_x      (link_x[lvl+1]),
         .out_valid (link_valid[lvl]),
         .out_idx   (link_idx[lvl]),
         .out_x     (link_x[lvl])
      );
   end

   assign done     = link_valid[0];
   assign done_idx = link_idx[0];

endmodule
